// ===== hdl/rcs_pkg.sv =====
package rcs_pkg;

  localparam int COORD_BITS   = 20;
  localparam int ANGLE_BITS   = 16;
  localparam int SCREEN_BITS  = 13;
  localparam int EDGE_MARGIN  = 5;
  localparam int RANGE_BITS   = 16;
  localparam int WIN_BITS     = 12;
  localparam int CFG_IDX_BITS = 3;

  localparam int CORDIC_STEPS = 15;
  localparam int CORDIC_START = 19898;
  localparam int TRIG_MAX     = 32767;

  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_RANGE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEFT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic signed [COORD_BITS-1:0] viewer_x;
    logic signed [COORD_BITS-1:0] viewer_y;
    logic [ANGLE_BITS-1:0]        heading;
  } in_word_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_x;
    logic [SCREEN_BITS-1:0] screen_y;
  } out_word_t;

  // Arctangent of 2^-i in units of a quarter turn over 16384.
  function automatic int atan_unit(input int i);
    int a;
    case (i)
      0:  a = 8192;
      1:  a = 4836;
      2:  a = 2555;
      3:  a = 1297;
      4:  a = 651;
      5:  a = 326;
      6:  a = 163;
      7:  a = 81;
      8:  a = 41;
      9:  a = 20;
      10: a = 10;
      11: a = 5;
      12: a = 3;
      default: a = 1;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/rcs_div.sv =====
module rcs_div import rcs_pkg::*; #(
  parameter int NUM_BITS  = 32,
  parameter int DEN_BITS  = 16,
  parameter int Q_BITS    = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [DEN_BITS-1:0]  den_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 valid_o,
  output logic [Q_BITS-1:0]    quot_o,
  output logic [SIDE_BITS-1:0] side_o
);

  localparam int WW = NUM_BITS + DEN_BITS + Q_BITS;

  logic [NUM_BITS-1:0]  rem_q   [Q_BITS];
  logic [DEN_BITS-1:0]  den_q   [Q_BITS];
  logic [Q_BITS-1:0]    quot_q  [Q_BITS];
  logic [SIDE_BITS-1:0] side_q  [Q_BITS];
  logic                 valid_q [Q_BITS];

  // One quotient bit per stage, most significant first. The caller
  // guarantees the quotient fits in Q_BITS.
  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    localparam int Bit = Q_BITS - 1 - k;
    logic [NUM_BITS-1:0]  rem_in;
    logic [DEN_BITS-1:0]  den_in;
    logic [Q_BITS-1:0]    quot_in;
    logic [SIDE_BITS-1:0] side_in;
    logic                 valid_in;
    logic [WW-1:0]        dsh;
    logic                 ge;
    logic [NUM_BITS-1:0]  rem_d;
    logic [Q_BITS-1:0]    quot_d;

    if (k == 0) begin : g_first
      assign rem_in   = num_i;
      assign den_in   = den_i;
      assign quot_in  = '0;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[k-1];
      assign den_in   = den_q[k-1];
      assign quot_in  = quot_q[k-1];
      assign side_in  = side_q[k-1];
      assign valid_in = valid_q[k-1];
    end

    always_comb begin
      dsh       = WW'(den_in) << Bit;
      ge        = WW'(rem_in) >= dsh;
      rem_d     = ge ? NUM_BITS'(WW'(rem_in) - dsh) : rem_in;
      quot_d    = quot_in;
      quot_d[Bit] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quot_q[k] <= quot_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[Q_BITS-1];
  assign quot_o  = quot_q[Q_BITS-1];
  assign side_o  = side_q[Q_BITS-1];

endmodule

// ===== hdl/rotate_clip_square_to_screen_core.sv =====
// Radar point plotter. Each input word carries a target position, a viewer
// position and a viewer heading; each output word carries the screen pixel
// where the target is drawn inside the radar window.
// Both channels use valid and stall; a word moves on a rising edge with valid
// high and stall low. Configuration is a plain write port (cfg_we_i,
// cfg_index_i, cfg_data_i) that must only be written while the pipeline is
// empty.
// From input to output a word passes one entry stage, fifteen CORDIC
// stages, trig, multiply and rotate stages, a clip setup stage, a 16 stage
// clip divider, a scale stage, a 12 stage scale divider and the place stage.
// Throughput is one word per cycle unless the output stalls; every stage
// holds one word. When the receiver stalls a waiting output word, the
// whole pipeline holds and in_stall_o is raised; nothing is dropped or
// repeated. Reset clears every valid bit and loads the register defaults:
// view range 3500, window at the origin, 200 by 150 pixels.
module rotate_clip_square_to_screen_core import rcs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [RANGE_BITS-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_word_t               out_word_o
);

  localparam int DW  = COORD_BITS + 1;
  localparam int CW  = 18;
  localparam int ZW  = 17;
  localparam int PW  = DW + 16;
  localparam int SW  = PW + 2;
  localparam int UW  = SW - 15;
  localparam int NW  = RANGE_BITS + UW;
  localparam int KW  = RANGE_BITS + 1;
  localparam int XW  = RANGE_BITS + WIN_BITS;
  localparam int LW  = 18;
  localparam int SDW = 4 + 2 * KW;

  // Configuration registers.
  logic [RANGE_BITS-1:0] view_range_q;
  logic [WIN_BITS-1:0]   window_left_q, window_top_q, window_width_q, window_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_range_q    <= 16'd3500;
      window_left_q   <= '0;
      window_top_q    <= '0;
      window_width_q  <= 12'd200;
      window_height_q <= 12'd150;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VIEW_RANGE:    view_range_q    <= cfg_data_i;
        REG_WINDOW_LEFT:   window_left_q   <= cfg_data_i[WIN_BITS-1:0];
        REG_WINDOW_TOP:    window_top_q    <= cfg_data_i[WIN_BITS-1:0];
        REG_WINDOW_WIDTH:  window_width_q  <= cfg_data_i[WIN_BITS-1:0];
        REG_WINDOW_HEIGHT: window_height_q <= cfg_data_i[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [RANGE_BITS-1:0] r_eff;
  assign r_eff = (view_range_q == '0) ? RANGE_BITS'(1) : view_range_q;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Entry and CORDIC stages. Index 0 is the entry register.
  logic signed [CW-1:0] cx_q   [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy_q   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz_q   [CORDIC_STEPS+1];
  logic [1:0]           quad_q [CORDIC_STEPS+1];
  logic signed [DW-1:0] dx_q   [CORDIC_STEPS+1];
  logic signed [DW-1:0] dy_q   [CORDIC_STEPS+1];
  logic                 cv_q   [CORDIC_STEPS+1];

  logic [15:0] ang16;
  assign ang16 = 16'(in_word_i.heading) << (16 - ANGLE_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0]   <= CW'(CORDIC_START);
      cy_q[0]   <= '0;
      cz_q[0]   <= ZW'({3'b000, ang16[13:0]});
      quad_q[0] <= ang16[15:14];
      dx_q[0]   <= {in_word_i.viewer_x[COORD_BITS-1], in_word_i.viewer_x}
                 - {in_word_i.target_x[COORD_BITS-1], in_word_i.target_x};
      dy_q[0]   <= {in_word_i.viewer_y[COORD_BITS-1], in_word_i.viewer_y}
                 - {in_word_i.target_y[COORD_BITS-1], in_word_i.target_y};
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [CW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      xs = cx_q[k] >>> k;
      ys = cy_q[k] >>> k;
      if (!cz_q[k][ZW-1]) begin
        x_d = cx_q[k] - ys;
        y_d = cy_q[k] + xs;
        z_d = cz_q[k] - ZW'(atan_unit(k));
      end else begin
        x_d = cx_q[k] + ys;
        y_d = cy_q[k] - xs;
        z_d = cz_q[k] + ZW'(atan_unit(k));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else if (en) begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[k+1]   <= x_d;
        cy_q[k+1]   <= y_d;
        cz_q[k+1]   <= z_d;
        quad_q[k+1] <= quad_q[k];
        dx_q[k+1]   <= dx_q[k];
        dy_q[k+1]   <= dy_q[k];
      end
    end
  end

  // Trig stage: saturate and map to the quadrant.
  logic signed [CW-1:0] sx, sy;
  logic signed [15:0]   c_d, s_d, c_q, s_q;
  logic signed [DW-1:0] dxt_q, dyt_q;
  logic                 tv_q;

  always_comb begin
    sx = cx_q[CORDIC_STEPS];
    sy = cy_q[CORDIC_STEPS];
    if (sx > CW'(TRIG_MAX)) sx = CW'(TRIG_MAX);
    if (sx < -CW'(TRIG_MAX)) sx = -CW'(TRIG_MAX);
    if (sy > CW'(TRIG_MAX)) sy = CW'(TRIG_MAX);
    if (sy < -CW'(TRIG_MAX)) sy = -CW'(TRIG_MAX);
    case (quad_q[CORDIC_STEPS])
      2'd0: begin
        c_d = 16'(sx);
        s_d = 16'(sy);
      end
      2'd1: begin
        c_d = -16'(sy);
        s_d = 16'(sx);
      end
      2'd2: begin
        c_d = -16'(sx);
        s_d = -16'(sy);
      end
      default: begin
        c_d = 16'(sy);
        s_d = -16'(sx);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else if (en) begin
      tv_q <= cv_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= c_d;
      s_q   <= s_d;
      dxt_q <= dx_q[CORDIC_STEPS];
      dyt_q <= dy_q[CORDIC_STEPS];
    end
  end

  // Multiply stage.
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic                 mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= tv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= PW'(dyt_q) * PW'(c_q);
      p2_q <= PW'(dxt_q) * PW'(s_q);
      p3_q <= PW'(dxt_q) * PW'(c_q);
      p4_q <= PW'(dyt_q) * PW'(s_q);
    end
  end

  // Rotate stage: round and drop the Q1.15 fraction.
  logic signed [SW-1:0] su, sv;
  logic signed [UW-1:0] u_q, v_q;
  logic                 rv_q;

  always_comb begin
    su = (SW'(p1_q) - SW'(p2_q) + SW'(16384)) >>> 15;
    sv = (SW'(p3_q) + SW'(p4_q) + SW'(16384)) >>> 15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= UW'(su);
      v_q <= UW'(sv);
    end
  end

  // Clip setup. The coordinate with the larger magnitude is the major one;
  // it lands on the square edge and the other is scaled by r over it.
  logic signed [UW-1:0] r_w, m_s, n_s;
  logic                 clip, maj_v;
  logic [UW-1:0]        m_mag, n_mag;
  logic [NW-1:0]        num_q;
  logic [UW-1:0]        den_q;
  logic [SDW-1:0]       side_d, side_q;
  logic                 pv_q;

  always_comb begin
    r_w   = UW'({1'b0, r_eff});
    clip  = (u_q > r_w) || (u_q < -r_w) || (v_q > r_w) || (v_q < -r_w);
    maj_v = (v_q > u_q) == (v_q > -u_q);
    m_s   = maj_v ? v_q : u_q;
    n_s   = maj_v ? u_q : v_q;
    m_mag = m_s[UW-1] ? UW'(-m_s) : UW'(m_s);
    n_mag = n_s[UW-1] ? UW'(-n_s) : UW'(n_s);
    side_d = {clip, maj_v, n_s[UW-1], m_s[UW-1], u_q[KW-1:0], v_q[KW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q  <= NW'(r_eff) * NW'(n_mag);
      den_q  <= m_mag;
      side_q <= side_d;
    end
  end

  logic                  d1v;
  logic [RANGE_BITS-1:0] d1q;
  logic [SDW-1:0]        d1s;

  rcs_div #(
    .NUM_BITS (NW),
    .DEN_BITS (UW),
    .Q_BITS   (RANGE_BITS),
    .SIDE_BITS(SDW)
  ) u_clip_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(pv_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_i (side_q),
    .valid_o(d1v),
    .quot_o (d1q),
    .side_o (d1s)
  );

  // Scale setup: pick the clipped or unclipped point and multiply by the window size.
  logic signed [KW-1:0] minor, major, cu, cv, u_pass, v_pass;
  logic [RANGE_BITS-1:0] ux_mag, vy_mag;
  logic [XW-1:0]         nx_q, ny_q;
  logic                  xneg_q, yneg_q, kv_q;

  always_comb begin
    u_pass = d1s[2*KW-1:KW];
    v_pass = d1s[KW-1:0];
    minor  = d1s[SDW-3] ? -KW'(d1q) : KW'(d1q);
    major  = d1s[SDW-4] ? -KW'(r_eff) : KW'(r_eff);
    if (d1s[SDW-1]) begin
      cu = d1s[SDW-2] ? minor : major;
      cv = d1s[SDW-2] ? major : minor;
    end else begin
      cu = u_pass;
      cv = v_pass;
    end
    ux_mag = cu[KW-1] ? RANGE_BITS'(-cu) : RANGE_BITS'(cu);
    vy_mag = cv[KW-1] ? RANGE_BITS'(-cv) : RANGE_BITS'(cv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q <= 1'b0;
    end else if (en) begin
      kv_q <= d1v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= XW'(ux_mag) * XW'(window_width_q);
      ny_q   <= XW'(vy_mag) * XW'(window_height_q);
      xneg_q <= cu[KW-1];
      yneg_q <= cv[KW-1];
    end
  end

  logic                d2v, d3v;
  logic [WIN_BITS-1:0] qx, qy;
  logic                xneg, yneg;

  rcs_div #(
    .NUM_BITS (XW),
    .DEN_BITS (RANGE_BITS),
    .Q_BITS   (WIN_BITS),
    .SIDE_BITS(1)
  ) u_x_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(kv_q),
    .num_i  (nx_q),
    .den_i  (r_eff),
    .side_i (xneg_q),
    .valid_o(d2v),
    .quot_o (qx),
    .side_o (xneg)
  );

  rcs_div #(
    .NUM_BITS (XW),
    .DEN_BITS (RANGE_BITS),
    .Q_BITS   (WIN_BITS),
    .SIDE_BITS(1)
  ) u_y_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(kv_q),
    .num_i  (ny_q),
    .den_i  (r_eff),
    .side_i (yneg_q),
    .valid_o(d3v),
    .quot_o (qy),
    .side_o (yneg)
  );

  // Place stage. The far clamp comes first, so a window narrower than the
  // margin ends up at its near edge.
  function automatic logic [SCREEN_BITS-1:0] place(input logic [WIN_BITS-1:0] q,
                                                   input logic neg,
                                                   input logic [WIN_BITS-1:0] origin,
                                                   input logic [WIN_BITS-1:0] size);
    logic signed [LW-1:0] p, far, org;
    org = LW'({1'b0, origin});
    p   = org + LW'({1'b0, size >> 1}) + (neg ? -LW'({1'b0, q}) : LW'({1'b0, q}));
    far = org + LW'({1'b0, size}) - LW'(EDGE_MARGIN);
    if (p > far) p = far;
    if (p < org) p = org;
    return p[SCREEN_BITS-1:0];
  endfunction

  out_word_t out_q;
  logic      ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= d2v && d3v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.screen_x <= place(qx, xneg, window_left_q, window_width_q);
      out_q.screen_y <= place(qy, yneg, window_top_q, window_height_q);
    end
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  // The input side only stalls behind a waiting output word.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting output word");

  // A held output freezes the middle of the pipeline.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(tv_q) && $stable(pv_q) && $stable(kv_q))
    else $error("pipeline moved while output was stalled");

  // An accepted word lands in the entry stage.
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> cv_q[0])
    else $error("accepted word lost at entry");

  // Both scale dividers run in lock step.
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2v == d3v)
    else $error("scale dividers out of step");

endmodule

// ===== bench/tb_rotate_clip_square_to_screen_core.sv =====
`timescale 1ns / 1ps
module tb_rotate_clip_square_to_screen_core;
  import rcs_pkg::*;

  localparam int LATENCY = 50;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_WORDS = 1030;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [RANGE_BITS-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  in_word_t                in_word_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  out_word_t               out_word_o;

  rotate_clip_square_to_screen_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  // Mirror of the configuration registers.
  logic [15:0] range_q;
  logic [11:0] left_q, top_q, width_q, height_q;

  out_word_t pixel_queue[$];
  int        mismatches;
  int        words_sent;
  int        pixels_seen;
  int        idle_cycles;
  int        clipped_seen;
  bit        stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint trunc_div(input longint num, input longint den);
    if (den == 0) return 0;
    return num / den;
  endfunction

  function automatic longint atan_table(input int i);
    case (i)
      0: return 8192;  1: return 4836;  2: return 2555;  3: return 1297;
      4: return 651;   5: return 326;   6: return 163;   7: return 81;
      8: return 41;    9: return 20;    10: return 10;   11: return 5;
      12: return 3;    default: return 1;
    endcase
  endfunction

  function automatic void heading_trig(input logic [15:0] ang, output longint c,
                                       output longint s);
    longint x, y, z, xs, ys;
    x = CORDIC_START;
    y = 0;
    z = ang[13:0];
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_table(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_table(i);
      end
    end
    if (x > TRIG_MAX) x = TRIG_MAX;
    if (x < -TRIG_MAX) x = -TRIG_MAX;
    if (y > TRIG_MAX) y = TRIG_MAX;
    if (y < -TRIG_MAX) y = -TRIG_MAX;
    case (ang[15:14])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [SCREEN_BITS-1:0] place_pixel(input longint coord,
      input longint r, input longint origin, input longint size);
    longint p, far_edge;
    p = origin + size / 2 + trunc_div(coord * size, r);
    far_edge = origin + size - EDGE_MARGIN;
    if (p > far_edge) p = far_edge;
    if (p < origin) p = origin;
    return p[SCREEN_BITS-1:0];
  endfunction

  function automatic out_word_t plot_point(input in_word_t w, output bit clipped);
    longint dx, dy, c, s, u, v, r;
    out_word_t o;
    dx = longint'(w.viewer_x) - longint'(w.target_x);
    dy = longint'(w.viewer_y) - longint'(w.target_y);
    r = (range_q == 0) ? 1 : longint'(range_q);
    heading_trig(w.heading, c, s);
    u = floor_shift(dy * c - dx * s + 16384, 15);
    v = floor_shift(dx * c + dy * s + 16384, 15);
    clipped = (u > r || u < -r || v > r || v < -r);
    if (clipped) begin
      if (v > u) begin
        if (v > -u) begin u = trunc_div(r * u, v); v = r; end
        else begin v = trunc_div(-r * v, u); u = -r; end
      end else begin
        if (v > -u) begin v = trunc_div(r * v, u); u = r; end
        else begin u = trunc_div(-r * u, v); v = -r; end
      end
    end
    o.screen_x = place_pixel(u, r, left_q, width_q);
    o.screen_y = place_pixel(v, r, top_q, height_q);
    return o;
  endfunction

  // Write enable stays high across back to back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_VIEW_RANGE:    range_q = val;
      REG_WINDOW_LEFT:   left_q = val[11:0];
      REG_WINDOW_TOP:    top_q = val[11:0];
      REG_WINDOW_WIDTH:  width_q = val[11:0];
      REG_WINDOW_HEIGHT: height_q = val[11:0];
      default: ;
    endcase
  endtask

  // Presents one word and holds it until accepted. Valid stays high when the
  // next call follows directly, so it is never dropped and raised in one step.
  task automatic send_word(input in_word_t w, input bit has_pixel, input out_word_t pixel);
    bit clipped;
    out_word_t predicted;
    predicted = plot_point(w, clipped);
    if (clipped) clipped_seen++;
    if (has_pixel && predicted !== pixel) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row %0d: table %0d,%0d predictor %0d,%0d", words_sent,
                 pixel.screen_x, pixel.screen_y, predicted.screen_x, predicted.screen_y);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixel_queue.push_back(has_pixel ? pixel : predicted);
    words_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [19:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 20'($urandom());
      1: return 20'(int'($urandom_range(0, 8000)) - 4000);
      2: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      default: return 20'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.target_x = rand_coord();
    w.target_y = rand_coord();
    w.viewer_x = rand_coord();
    w.viewer_y = rand_coord();
    w.heading = 16'($urandom());
    return w;
  endfunction

  typedef struct {
    in_word_t  word;
    bit        has_pixel;
    out_word_t pixel;
  } plot_row_t;

  plot_row_t directed_rows[$];

  function automatic in_word_t mk(input int tx, input int ty, input int vx, input int vy,
                                  input int hd);
    in_word_t w;
    w.target_x = 20'(tx); w.target_y = 20'(ty);
    w.viewer_x = 20'(vx); w.viewer_y = 20'(vy);
    w.heading = 16'(hd);
    return w;
  endfunction

  initial begin
    out_word_t none;
    none = '0;
    // Viewer on target lands at the window center with reset registers.
    directed_rows.push_back('{mk(0, 0, 0, 0, 0), 1'b1, '{13'd100, 13'd75}});
    directed_rows.push_back('{mk(5, -7, 5, -7, 16'hFFFF), 1'b1, '{13'd100, 13'd75}});
    // Far points hit the square and clamp on the window edges; nearer points are mixed in.
    directed_rows.push_back('{mk(0, 20'h80000, 0, 20'h7FFFF, 0), 1'b0, none});
    directed_rows.push_back('{mk(20'h7FFFF, 0, 20'h80000, 0, 0), 1'b0, none});
    directed_rows.push_back('{mk(20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 0), 1'b0, none});
    directed_rows.push_back('{mk(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 0), 1'b0, none});
    directed_rows.push_back('{mk(100, 0, 0, 0, 16'h4000), 1'b0, none});
    directed_rows.push_back('{mk(0, 100, 0, 0, 16'h8000), 1'b0, none});
    directed_rows.push_back('{mk(-100, 50, 0, 0, 16'hC000), 1'b0, none});
    directed_rows.push_back('{mk(3500, 0, 0, 0, 16'h2000), 1'b0, none});
    directed_rows.push_back('{mk(0, -3501, 0, 0, 16'h3FFF), 1'b0, none});
    directed_rows.push_back('{mk(1000, -9000, 0, 0, 16'h0001), 1'b0, none});
    directed_rows.push_back('{mk(-9000, -9000, 0, 0, 16'h6000), 1'b0, none});
    directed_rows.push_back('{mk(9000, -3000, 0, 0, 16'hE000), 1'b0, none});
    directed_rows.push_back('{mk(-3000, 9000, 0, 0, 16'hA000), 1'b0, none});
    directed_rows.push_back('{mk(20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555, 16'hAAAA),
                              1'b0, none});
  end

  // Receiver: checks each pixel word against the oldest queued expected pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %0d,%0d",
                                       out_word_o.screen_x, out_word_o.screen_y);
      end else begin
        out_word_t exp_pix;
        exp_pix = pixel_queue.pop_front();
        if (out_word_o.screen_x !== exp_pix.screen_x ||
            out_word_o.screen_y !== exp_pix.screen_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel %0d: expected %0d,%0d got %0d,%0d", pixels_seen,
                     exp_pix.screen_x, exp_pix.screen_y,
                     out_word_o.screen_x, out_word_o.screen_y);
        end
      end
      pixels_seen++;
    end
  end

  // Receiver stall pattern: stretches of random stalls alternating with none.
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= stall_enable && ($urandom_range(0, 99) < 35);
    if ($urandom_range(0, 199) == 0) stall_enable = ~stall_enable;
  end

  // Watchdog on cycles in which no word moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic random_phase(input int count);
    int left_in_burst;
    left_in_burst = 0;
    for (int n = 0; n < count; n++) begin
      if (left_in_burst == 0) begin
        left_in_burst = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
      left_in_burst--;
      send_word(rand_word(), 1'b0, '0);
      // Sender waits for an empty pipeline now and then.
      if ($urandom_range(0, 299) == 0) drain_pipeline();
    end
  endtask

  initial begin
    int settings[7][5];
    mismatches = 0; words_sent = 0; pixels_seen = 0; idle_cycles = 0;
    clipped_seen = 0; stall_enable = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; in_word_i = '0;
    range_q = 16'd3500; left_q = '0; top_q = '0; width_q = 12'd200; height_q = 12'd150;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].has_pixel, directed_rows[i].pixel);
    drain_pipeline();

    // Range, left, top, width, height; zero range and narrow windows included.
    settings = '{'{1, 0, 0, 1, 1}, '{65535, 4095, 4095, 4095, 4095},
                 '{0, 100, 50, 3, 4}, '{250, 10, 20, 640, 480},
                 '{40000, 8000, 300, 200, 150}, '{3500, 0, 0, 200, 150},
                 '{16, 4000, 4000, 4095, 4095}};
    stall_enable = 1'b1;
    for (int p = 0; p < 7; p++) begin
      for (int r = 0; r < 5; r++)
        write_reg(CFG_IDX_BITS'(r), 16'(settings[p][r]));
      cfg_we_i <= 1'b0;
      random_phase(RANDOM_WORDS / 7);
      drain_pipeline();
    end

    $display("%0d words sent, %0d pixels checked, %0d points clipped onto the square",
             words_sent, pixels_seen, clipped_seen);
    $display("seven register settings covered, from the smallest range to the widest window");
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== rotate_clip_square_to_screen_core.f =====
hdl/rcs_pkg.sv
hdl/rcs_div.sv
hdl/rotate_clip_square_to_screen_core.sv
bench/tb_rotate_clip_square_to_screen_core.sv
